### rtl/fbpa_pkg.sv
// Shared constants, command and status codes, and the control structs of the
// fixed block pool allocator. Used by every module in rtl/.
`default_nettype none

package fbpa_pkg;

    localparam int POOL_DEPTH_DEFAULT = 256;

    localparam int CMD_W = 2;
    localparam int IDX_W = 8;
    localparam int ST_W  = 2;
    localparam int CNT_W = 9;

    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REINIT = 2'd2;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [ST_W-1:0] ST_FOREIGN = 2'd2;

    typedef struct packed {
        logic load;
        logic pop;
    } ctrl_cmd_t;

    typedef struct packed {
        logic list_pop;
    } dp_status_t;

endpackage

`default_nettype wire

### rtl/fbpa_ctrl.sv
// Controller of the fixed block pool allocator: handshake, output valid and
// the pop state. Depends on fbpa_pkg.
`default_nettype none

module fbpa_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    output logic                     out_valid,
    input  wire logic                out_stall,
    input  wire fbpa_pkg::dp_status_t stat,
    output fbpa_pkg::ctrl_cmd_t      cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_POP  = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    always_comb
    begin
        in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
        accept   = in_valid && !in_stall;
        cmd.load = accept;
        cmd.pop  = (state_reg == S_POP);

        case (state_reg)
            S_IDLE:
            begin
                state_next = (accept && stat.list_pop) ? S_POP : S_IDLE;
            end
            S_POP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

### rtl/fbpa_dp.sv
// Datapath of the fixed block pool allocator: free-list link memory, list head,
// fresh index and live count, size register and result word. Depends on fbpa_pkg.
`default_nettype none

module fbpa_dp #(
    parameter int POOL_DEPTH = fbpa_pkg::POOL_DEPTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [fbpa_pkg::CNT_W-1:0]    cfg_data,
    input  wire logic [fbpa_pkg::CMD_W-1:0]    command,
    input  wire logic [fbpa_pkg::IDX_W-1:0]    block_index,
    input  wire fbpa_pkg::ctrl_cmd_t           cmd,
    output fbpa_pkg::dp_status_t               stat,
    output logic [fbpa_pkg::IDX_W-1:0]         granted_index,
    output logic [fbpa_pkg::ST_W-1:0]          status,
    output logic [fbpa_pkg::CNT_W-1:0]         active_count
);

    localparam int IW = $clog2(POOL_DEPTH);
    localparam int LW = $clog2(POOL_DEPTH + 1);
    localparam int KW = (LW > fbpa_pkg::CNT_W) ? LW : fbpa_pkg::CNT_W;
    localparam logic [LW-1:0] EMPTY  = LW'(POOL_DEPTH);
    localparam logic [KW-1:0] DEPTHK = KW'(POOL_DEPTH);

    logic [LW-1:0] link_mem [POOL_DEPTH];

    logic [fbpa_pkg::CNT_W-1:0] size_cfg_reg;
    logic [LW-1:0]              head_reg;
    logic [LW-1:0]              head_next;
    logic [LW-1:0]              fresh_reg;
    logic [LW-1:0]              fresh_next;
    logic [LW-1:0]              live_reg;
    logic [LW-1:0]              live_next;
    logic [LW-1:0]              link_rd_reg;

    logic [KW-1:0]              size_cfg_k;
    logic [KW-1:0]              size_k;
    logic [KW-1:0]              idx_k;
    logic                       list_nonempty;
    logic                       got;
    logic                       push;
    logic [LW-1:0]              granted;
    logic [fbpa_pkg::ST_W-1:0]  st;

    logic [fbpa_pkg::IDX_W-1:0] granted_reg;
    logic [fbpa_pkg::ST_W-1:0]  status_reg;
    logic [fbpa_pkg::CNT_W-1:0] count_reg;

    always_comb
    begin
        size_cfg_k    = KW'(size_cfg_reg);
        size_k        = (size_cfg_k < DEPTHK) ? size_cfg_k : DEPTHK;
        idx_k         = KW'(block_index);
        list_nonempty = (head_reg != EMPTY);

        head_next  = head_reg;
        fresh_next = fresh_reg;
        live_next  = live_reg;
        granted    = '0;
        st         = fbpa_pkg::ST_OK;
        got        = 1'b0;
        push       = 1'b0;

        stat.list_pop = (command == fbpa_pkg::CMD_ALLOC) && list_nonempty;

        case (command)
            fbpa_pkg::CMD_ALLOC:
            begin
                if (list_nonempty)
                begin
                    granted = head_reg;
                    got     = 1'b1;
                end
                else if (KW'(fresh_reg) < size_k)
                begin
                    granted    = fresh_reg;
                    fresh_next = fresh_reg + LW'(1);
                    got        = 1'b1;
                end
                else
                begin
                    st = fbpa_pkg::ST_EMPTY;
                end
                if (got && (live_reg != EMPTY))
                begin
                    live_next = live_reg + LW'(1);
                end
            end
            fbpa_pkg::CMD_FREE:
            begin
                if (idx_k >= size_k)
                begin
                    st = fbpa_pkg::ST_FOREIGN;
                end
                else
                begin
                    push      = 1'b1;
                    head_next = LW'(idx_k);
                    if (live_reg != '0)
                    begin
                        live_next = live_reg - LW'(1);
                    end
                end
            end
            fbpa_pkg::CMD_REINIT:
            begin
                head_next  = EMPTY;
                fresh_next = '0;
                live_next  = '0;
            end
            default:
            begin
                st = fbpa_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && push)
        begin
            link_mem[IW'(idx_k)] <= head_reg;
        end
        if (cmd.load)
        begin
            link_rd_reg <= link_mem[IW'(head_reg)];
            granted_reg <= fbpa_pkg::IDX_W'(granted);
            status_reg  <= st;
            count_reg   <= fbpa_pkg::CNT_W'(live_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_cfg_reg <= fbpa_pkg::CNT_W'(256);
            head_reg     <= EMPTY;
            fresh_reg    <= '0;
            live_reg     <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                size_cfg_reg <= cfg_data;
            end
            if (cmd.pop)
            begin
                head_reg <= link_rd_reg;
            end
            else if (cmd.load)
            begin
                head_reg  <= head_next;
                fresh_reg <= fresh_next;
                live_reg  <= live_next;
            end
        end
    end

    assign granted_index = granted_reg;
    assign status        = status_reg;
    assign active_count  = count_reg;

endmodule

`default_nettype wire

### rtl/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator: joins controller and datapath.
// Depends on fbpa_pkg, fbpa_ctrl and fbpa_dp.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one word: command and
//   block_index. Output channel (out_valid / out_stall) returns one word per
//   input word: granted_index, status and active_count.
//   cfg_write / cfg_data set the managed block count; write only while idle.
// Results: the result word is registered at the edge that accepts its word.
// Throughput: one word per cycle while out_stall holds no result, except an
//   allocate served from the free list, which stalls input for the pop state;
//   the pop state reloads the list head from the registered link memory read.
// Reset: empty free list, no blocks handed out, block count 256. The link
//   memory is not cleared; entries are used only after a free has written them.
// Back-pressure: while out_stall holds a waiting result, in_stall is raised
//   and the result word holds.
`default_nettype none

module fixed_block_pool_allocator #(
    parameter int POOL_DEPTH = fbpa_pkg::POOL_DEPTH_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write,
    input  wire logic [fbpa_pkg::CNT_W-1:0] cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [fbpa_pkg::CMD_W-1:0] command,
    input  wire logic [fbpa_pkg::IDX_W-1:0] block_index,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [fbpa_pkg::IDX_W-1:0]      granted_index,
    output logic [fbpa_pkg::ST_W-1:0]       status,
    output logic [fbpa_pkg::CNT_W-1:0]      active_count
);

    fbpa_pkg::ctrl_cmd_t  ctl;
    fbpa_pkg::dp_status_t dstat;

    fbpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (dstat),
        .cmd       (ctl)
    );

    fbpa_dp #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .command       (command),
        .block_index   (block_index),
        .cmd           (ctl),
        .stat          (dstat),
        .granted_index (granted_index),
        .status        (status),
        .active_count  (active_count)
    );

`ifndef SYNTH
    a_pop_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && dstat.list_pop) |=> in_stall)
        else $error("input taken during free-list pop");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("accepted word produced no result");

    a_empty_grants_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == fbpa_pkg::ST_EMPTY)) |-> (granted_index == '0))
        else $error("failed allocate reports a nonzero index");
`endif

endmodule

`default_nettype wire
